// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the ring store RTL.
// Needs nothing; NO_ASSERTIONS turns every macro into an empty line.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TBRS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TBRS_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define TBRS_ASSERT(lbl, clk, rst_n, prop, msg)
`define TBRS_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== rtl/core/tbrs_pkg.sv =====
// Shared types and constants of the time-bucketed ring store.
// Used by the controller, datapath, divider and top level.
package tbrs_pkg;

	localparam int ROWS_DEF = 1024;
	localparam int TIME_W   = 64;
	localparam int VAL_W    = 32;
	localparam int OP_W     = 2;

	localparam logic [OP_W-1:0] OP_ADD = 2'd0;
	localparam logic [OP_W-1:0] OP_SET = 2'd1;
	localparam logic [OP_W-1:0] OP_GET = 2'd2;

	localparam logic signed [VAL_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] INT_MIN = 32'sh8000_0000;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DIV,
		ST_EVAL,
		ST_ROUTE,
		ST_SWEEP,
		ST_READ,
		ST_MODIFY,
		ST_MUL,
		ST_LOAD
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic div_step;
		logic eval;
		logic sweep_step;
		logic read;
		logic modify;
		logic mul_step;
		logic load;
	} tbrs_cmd_t;

	typedef struct packed {
		logic div_last;
		logic err;
		logic adv;
		logic sweep_last;
		logic mul_last;
		logic out_free;
	} tbrs_sts_t;

endpackage

// ===== rtl/core/tbrs_div.sv =====
// Restoring 64-bit unsigned divider, one quotient bit per cycle in which step is high.
// Depends on tbrs_pkg for the word width.
module tbrs_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         step,
	input  logic [tbrs_pkg::TIME_W-1:0]  dividend,
	input  logic [tbrs_pkg::TIME_W-1:0]  divisor,
	output logic [tbrs_pkg::TIME_W-1:0]  quotient,
	output logic                         last
);
	import tbrs_pkg::*;

	localparam int CNT_W = $clog2(TIME_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIME_W - 1);

	logic [TIME_W-1:0] quo_q;
	logic [TIME_W-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TIME_W:0]   rem_sh;
	logic [TIME_W:0]   rem_sub;
	logic              ge;

	assign rem_sh  = {rem_q, quo_q[TIME_W-1]};
	assign ge      = rem_sh >= {1'b0, divisor};
	assign rem_sub = rem_sh - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (step) begin
			quo_q <= {quo_q[TIME_W-2:0], ge};
			rem_q <= ge ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign last     = cnt_q == CNT_LAST;

endmodule

// ===== rtl/core/tbrs_dp.sv =====
// Datapath: slot register, divider, window compare, bucket memory,
// clear sweep, 64-bit multiply and output register. Depends on tbrs_pkg, tbrs_div.
module tbrs_dp #(
	parameter int ROWS = tbrs_pkg::ROWS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tbrs_pkg::tbrs_cmd_t                cmd,
	output tbrs_pkg::tbrs_sts_t                sts,
	input  logic                               cfg_we,
	input  logic [tbrs_pkg::TIME_W-1:0]        cfg_data,
	input  logic [tbrs_pkg::OP_W-1:0]          opcode,
	input  logic [tbrs_pkg::TIME_W-1:0]        time_ns,
	input  logic signed [tbrs_pkg::VAL_W-1:0]  sample_value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               status,
	output logic signed [tbrs_pkg::VAL_W-1:0]  bucket_value,
	output logic [tbrs_pkg::TIME_W-1:0]        newest_slot_start
);
	import tbrs_pkg::*;

	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CNT_W = ROW_W + 1;
	localparam int HALF  = TIME_W / 2;
	localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
	localparam logic [CNT_W-1:0]  ROWS_CNT = CNT_W'(ROWS);
	localparam logic [TIME_W-1:0] ROWS_T   = TIME_W'(ROWS);

	function automatic logic [ROW_W-1:0] next_row(input logic [ROW_W-1:0] p);
		return (p == LAST_ROW) ? '0 : p + 1'b1;
	endfunction

	// configuration
	logic [TIME_W-1:0] len_q;
	logic [TIME_W-1:0] eff_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= TIME_W'(1);
		end else if (cfg_we) begin
			len_q <= cfg_data;
		end
	end

	assign eff_len = (len_q == '0) ? TIME_W'(1) : len_q;

	// request capture and slot division
	logic [OP_W-1:0]         op_q;
	logic signed [VAL_W-1:0] val_q;
	logic [TIME_W-1:0]       quo;
	logic                    writes;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= opcode;
			val_q <= sample_value;
		end
	end

	assign writes = (op_q == OP_ADD) || (op_q == OP_SET);

	tbrs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.accept),
		.step     (cmd.div_step),
		.dividend (time_ns),
		.divisor  (eff_len),
		.quotient (quo),
		.last     (sts.div_last)
	);

	// window evaluation
	logic [TIME_W-1:0] newest_q;
	logic [ROW_W-1:0]  pos_q;
	logic              err_q;
	logic              adv_q;
	logic [ROW_W-1:0]  idx_q;
	logic [ROW_W-1:0]  sw_ptr_q;
	logic [CNT_W-1:0]  sw_left_q;
	logic              sw_move_q;

	logic              gt;
	logic [TIME_W-1:0] delta;
	logic [TIME_W-1:0] age;
	logic              full;
	logic              old;
	logic [ROW_W-1:0]  age_r;
	logic [CNT_W-1:0]  wrap_sum;
	logic [ROW_W-1:0]  idx_c;

	assign gt       = quo > newest_q;
	assign delta    = quo - newest_q;
	assign age      = newest_q - quo;
	assign full     = delta >= ROWS_T;
	assign old      = age >= ROWS_T;
	assign age_r    = age[ROW_W-1:0];
	assign wrap_sum = {1'b0, pos_q} + ROWS_CNT - {1'b0, age_r};
	assign idx_c    = (pos_q >= age_r) ? pos_q - age_r : wrap_sum[ROW_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q  <= TIME_W'(ROWS - 1);
			pos_q     <= LAST_ROW;
			err_q     <= 1'b0;
			adv_q     <= 1'b0;
			sw_ptr_q  <= '0;
			sw_left_q <= ROWS_CNT;
			sw_move_q <= 1'b0;
		end else if (cmd.eval) begin
			err_q <= gt ? !writes : old;
			adv_q <= gt && writes;
			if (gt && writes) begin
				newest_q <= quo;
				if (full) begin
					sw_ptr_q  <= '0;
					sw_left_q <= ROWS_CNT;
					sw_move_q <= 1'b0;
				end else begin
					sw_ptr_q  <= next_row(pos_q);
					sw_left_q <= {1'b0, delta[ROW_W-1:0]};
					sw_move_q <= 1'b1;
				end
			end
		end else if (cmd.sweep_step) begin
			sw_ptr_q  <= next_row(sw_ptr_q);
			sw_left_q <= sw_left_q - 1'b1;
			if (sw_move_q) begin
				pos_q <= sw_ptr_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			idx_q <= idx_c;
		end
	end

	assign sts.err        = err_q;
	assign sts.adv        = adv_q;
	assign sts.sweep_last = sw_left_q == CNT_W'(1);

	// bucket memory
	logic signed [VAL_W-1:0] mem [ROWS];
	logic [ROW_W-1:0]        addr_q;
	logic [ROW_W-1:0]        rd_addr;
	logic signed [VAL_W-1:0] rd_data_q;
	logic signed [VAL_W-1:0] result_q;
	logic signed [VAL_W:0]   sum;
	logic signed [VAL_W-1:0] sat;
	logic signed [VAL_W-1:0] new_val;
	logic                    we;
	logic [ROW_W-1:0]        waddr;
	logic signed [VAL_W-1:0] wdata;

	assign rd_addr = adv_q ? pos_q : idx_q;

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			addr_q    <= rd_addr;
			rd_data_q <= mem[rd_addr];
		end
	end

	assign sum = {rd_data_q[VAL_W-1], rd_data_q} + {val_q[VAL_W-1], val_q};

	always_comb begin
		if (sum[VAL_W] != sum[VAL_W-1]) begin
			sat = sum[VAL_W] ? INT_MIN : INT_MAX;
		end else begin
			sat = sum[VAL_W-1:0];
		end
		priority if (op_q == OP_ADD) begin
			new_val = sat;
		end else if (op_q == OP_SET) begin
			new_val = val_q;
		end else begin
			new_val = rd_data_q;
		end
	end

	assign we    = cmd.sweep_step || (cmd.modify && writes);
	assign waddr = cmd.sweep_step ? sw_ptr_q : addr_q;
	assign wdata = cmd.sweep_step ? '0 : new_val;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.modify) begin
			result_q <= new_val;
		end
	end

	// newest_row * length, low 64 bits from three 32x32 products
	logic [1:0]        mul_cnt_q;
	logic [TIME_W-1:0] prod_q;
	logic [TIME_W-1:0] acc_q;
	logic [HALF-1:0]   mul_a;
	logic [HALF-1:0]   mul_b;

	assign mul_a = (mul_cnt_q == 2'd2) ? newest_q[TIME_W-1:HALF] : newest_q[HALF-1:0];
	assign mul_b = (mul_cnt_q == 2'd1) ? eff_len[TIME_W-1:HALF] : eff_len[HALF-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_cnt_q <= '0;
		end else if (cmd.mul_step) begin
			mul_cnt_q <= mul_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_step) begin
			prod_q <= TIME_W'(mul_a) * TIME_W'(mul_b);
			unique case (mul_cnt_q)
				2'd0: acc_q <= acc_q;
				2'd1: acc_q <= prod_q;
				2'd2, 2'd3: acc_q <= acc_q + {prod_q[HALF-1:0], {HALF{1'b0}}};
			endcase
		end
	end

	assign sts.mul_last = mul_cnt_q == 2'd3;

	// result register
	logic                    out_valid_q;
	logic                    status_q;
	logic signed [VAL_W-1:0] bucket_q;
	logic [TIME_W-1:0]       start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q <= err_q;
			bucket_q <= err_q ? INT_MIN : result_q;
			start_q  <= acc_q;
		end
	end

	assign sts.out_free       = !out_valid_q || out_ready;
	assign out_valid          = out_valid_q;
	assign status             = status_q;
	assign bucket_value       = bucket_q;
	assign newest_slot_start  = start_q;

endmodule

// ===== rtl/core/tbrs_ctrl.sv =====
// Controller state machine of the ring store: sequences reset clear, divide,
// window check, clear sweep, bucket update, multiply, load. Depends on tbrs_pkg.
module tbrs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tbrs_pkg::tbrs_sts_t  sts,
	output tbrs_pkg::tbrs_cmd_t  cmd
);
	import tbrs_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT:   if (sts.sweep_last) state_d = ST_IDLE;
			ST_IDLE:   if (in_valid) state_d = ST_DIV;
			ST_DIV:    if (sts.div_last) state_d = ST_EVAL;
			ST_EVAL:   state_d = ST_ROUTE;
			ST_ROUTE: begin
				priority if (sts.adv) begin
					state_d = ST_SWEEP;
				end else if (sts.err) begin
					state_d = ST_MUL;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_SWEEP:  if (sts.sweep_last) state_d = ST_READ;
			ST_READ:   state_d = ST_MODIFY;
			ST_MODIFY: state_d = ST_MUL;
			ST_MUL:    if (sts.mul_last) state_d = ST_LOAD;
			ST_LOAD:   if (sts.out_free) state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_INIT:   cmd.sweep_step = 1'b1;
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_DIV:    cmd.div_step = 1'b1;
			ST_EVAL:   cmd.eval = 1'b1;
			ST_ROUTE:  cmd = '0;
			ST_SWEEP:  cmd.sweep_step = 1'b1;
			ST_READ:   cmd.read = 1'b1;
			ST_MODIFY: cmd.modify = 1'b1;
			ST_MUL:    cmd.mul_step = 1'b1;
			ST_LOAD:   cmd.load = sts.out_free;
		endcase
	end

endmodule

// ===== rtl/core/time_bucketed_ring_store.sv =====
// Time-bucketed ring store: ROWS signed 32-bit buckets, one per slot of
// slot_length_ns nanoseconds, addressed by time_ns / slot length.
// Input channel in_valid/in_ready carries opcode (add, set, get), time_ns
// and sample_value; one request is taken at a time. Output channel
// out_valid/out_ready returns status, bucket_value and newest_slot_start,
// one result per request, held in an output register so the next request
// is accepted while a result still waits.
// Config channel cfg_valid/cfg_ready writes slot_length_ns (always ready).
// Each request runs through the bit-serial divider, the window check, the
// bucket read and modify and the shared 32x32 multiplier before its result
// is loaded; when an add or set advances the window, a clear sweep ahead
// of the bucket read zeroes one bucket per slot of the jump, or ROWS
// buckets when the jump reaches ROWS. A refused request skips the bucket
// access. A new request can be taken in the cycle after the result is loaded.
// After reset all ROWS buckets are cleared in one sweep, during
// which in_ready stays low. If out_ready stays low the finished result is
// held and the next request waits in its last step until the register frees.
`include "assert_macros.svh"
module time_bucketed_ring_store #(
	parameter int ROWS = tbrs_pkg::ROWS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tbrs_pkg::TIME_W-1:0]        slot_length_ns,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [tbrs_pkg::OP_W-1:0]          opcode,
	input  logic [tbrs_pkg::TIME_W-1:0]        time_ns,
	input  logic signed [tbrs_pkg::VAL_W-1:0]  sample_value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               status,
	output logic signed [tbrs_pkg::VAL_W-1:0]  bucket_value,
	output logic [tbrs_pkg::TIME_W-1:0]        newest_slot_start
);
	import tbrs_pkg::*;

	tbrs_cmd_t cmd;
	tbrs_sts_t sts;

	assign cfg_ready = 1'b1;

	tbrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tbrs_dp #(
		.ROWS (ROWS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.cfg_we            (cfg_valid),
		.cfg_data          (slot_length_ns),
		.opcode            (opcode),
		.time_ns           (time_ns),
		.sample_value      (sample_value),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.status            (status),
		.bucket_value      (bucket_value),
		.newest_slot_start (newest_slot_start)
	);

	`TBRS_ASSERT(a_err_min, clk, arst_n, out_valid && status |-> bucket_value == INT_MIN, "error result without INT_MIN")
	`TBRS_NEVER(a_load_busy, clk, arst_n, cmd.load && out_valid && !out_ready, "result overwritten")
	`TBRS_ASSERT(a_one_request, clk, arst_n, in_valid && in_ready |=> !in_ready, "second request taken")
	`TBRS_NEVER(a_err_write, clk, arst_n, cmd.modify && sts.err, "bucket touched on error")

endmodule

// ===== tb/ring_store_checker.sv =====
// Checker for the time-bucketed ring store: watches the config, request and result channels,
// keeps its own copy of the bucket ring, and compares every result with its prediction.
// Depends on tbrs_pkg for widths, opcodes and the saturation limits.
module ring_store_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [tbrs_pkg::TIME_W-1:0]         slot_length_ns,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic [tbrs_pkg::OP_W-1:0]           opcode,
	input  logic [tbrs_pkg::TIME_W-1:0]         time_ns,
	input  logic signed [tbrs_pkg::VAL_W-1:0]   sample_value,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic                                status,
	input  logic signed [tbrs_pkg::VAL_W-1:0]   bucket_value,
	input  logic [tbrs_pkg::TIME_W-1:0]         newest_slot_start,
	output int                                  mismatches,
	output int                                  pending,
	output int                                  checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import tbrs_pkg::*;

	localparam int NUM_ROWS = ROWS_DEF;

	typedef struct packed {
		logic                    refused;
		logic signed [VAL_W-1:0] value;
		logic [TIME_W-1:0]       slot_start;
	} bucket_result_t;

	logic [TIME_W-1:0]       length_reg;
	logic [TIME_W-1:0]       newest_row;
	logic signed [VAL_W-1:0] buckets [NUM_ROWS];
	bucket_result_t          expected_results [$];

	function automatic bucket_result_t predict_request(
		input logic [OP_W-1:0]         op,
		input logic [TIME_W-1:0]       t,
		input logic signed [VAL_W-1:0] v
	);
		logic [TIME_W-1:0] len;
		logic [TIME_W-1:0] slot;
		logic [TIME_W-1:0] jump;
		logic [TIME_W-1:0] pos;
		logic              writes;
		longint            sum;
		int                idx;
		int                k;
		bucket_result_t    r;
		len = (length_reg == '0) ? 64'd1 : length_reg;
		slot = t / len;
		writes = (op == OP_ADD) || (op == OP_SET);
		r.refused = 1'b0;
		r.value = INT_MIN;
		if (slot > newest_row) begin
			if (writes) begin
				jump = slot - newest_row;
				if (jump >= NUM_ROWS) begin
					for (k = 0; k < NUM_ROWS; k++) buckets[k] = '0;
				end else begin
					pos = newest_row % NUM_ROWS;
					for (k = 0; k < int'(jump); k++) begin
						pos = (pos + 1) % NUM_ROWS;
						buckets[int'(pos)] = '0;
					end
				end
				newest_row = slot;
			end else begin
				r.refused = 1'b1;
			end
		end else if (newest_row - slot >= NUM_ROWS) begin
			r.refused = 1'b1;
		end
		if (!r.refused) begin
			idx = int'(slot % NUM_ROWS);
			if (op == OP_ADD) begin
				sum = longint'(buckets[idx]) + longint'(v);
				if (sum > longint'(INT_MAX)) sum = longint'(INT_MAX);
				else if (sum < longint'(INT_MIN)) sum = longint'(INT_MIN);
				buckets[idx] = VAL_W'(sum);
			end else if (op == OP_SET) begin
				buckets[idx] = v;
			end
			r.value = buckets[idx];
		end
		r.slot_start = newest_row * len;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bucket_result_t want;
		int             bad;
		if (!arst_n) begin
			length_reg = 64'd1;
			newest_row = TIME_W'(NUM_ROWS - 1);
			foreach (buckets[i]) buckets[i] = '0;
			expected_results.delete();
			mismatches <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			bad = 0;
			if (cfg_valid && cfg_ready)
				length_reg = slot_length_ns;
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result with no request outstanding: status %0b bucket_value %0d",
						status, bucket_value);
					bad++;
				end else begin
					want = expected_results.pop_front();
					if (status !== want.refused) begin
						$error("status: expected %0b, got %0b", want.refused, status);
						bad++;
					end
					if (bucket_value !== want.value) begin
						$error("bucket_value: expected %0d, got %0d", want.value, bucket_value);
						bad++;
					end
					if (newest_slot_start !== want.slot_start) begin
						$error("newest_slot_start: expected %0d, got %0d",
							want.slot_start, newest_slot_start);
						bad++;
					end
					checked <= checked + 1;
				end
			end
			if (in_valid && in_ready)
				expected_results.push_back(predict_request(opcode, time_ns, sample_value));
			mismatches <= mismatches + bad;
			pending <= expected_results.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
// Top of the ring store testbench: clock, reset, request and config stimulus, result stalls,
// watchdog and verdict. Needs tbrs_pkg, time_bucketed_ring_store and ring_store_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tbrs_pkg::*;

	localparam int                NUM_ROWS    = ROWS_DEF;
	localparam logic [OP_W-1:0]   OP_SPARE    = 2'd3;
	localparam logic [TIME_W-1:0] ALL_ONES    = '1;
	localparam int                QUIET_LIMIT = 20000;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [TIME_W-1:0]       slot_length_ns = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [OP_W-1:0]         opcode = OP_GET;
	logic [TIME_W-1:0]       time_ns = '0;
	logic signed [VAL_W-1:0] sample_value = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic                    status;
	logic signed [VAL_W-1:0] bucket_value;
	logic [TIME_W-1:0]       newest_slot_start;

	int mismatches;
	int pending;
	int checked;

	// stimulus-side view of the window, used only to aim timestamps
	logic [TIME_W-1:0] cur_len = 64'd1;
	logic [TIME_W-1:0] cursor = TIME_W'(NUM_ROWS - 1);
	int                sent = 0;
	int                directed = 0;
	int                settings = 0;
	int                quiet = 0;
	int                seen = 0;

	always #5ns clk = ~clk;

	time_bucketed_ring_store dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.slot_length_ns    (slot_length_ns),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.opcode            (opcode),
		.time_ns           (time_ns),
		.sample_value      (sample_value),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.status            (status),
		.bucket_value      (bucket_value),
		.newest_slot_start (newest_slot_start)
	);

	ring_store_checker result_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.slot_length_ns    (slot_length_ns),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.opcode            (opcode),
		.time_ns           (time_ns),
		.sample_value      (sample_value),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.status            (status),
		.bucket_value      (bucket_value),
		.newest_slot_start (newest_slot_start),
		.mismatches        (mismatches),
		.pending           (pending),
		.checked           (checked)
	);

	task automatic send_req(
		input logic [OP_W-1:0]         op,
		input logic [TIME_W-1:0]       t,
		input logic signed [VAL_W-1:0] v
	);
		logic [TIME_W-1:0] slot;
		opcode <= op;
		time_ns <= t;
		sample_value <= v;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		slot = t / cur_len;
		if ((op == OP_ADD || op == OP_SET) && slot > cursor)
			cursor = slot;
		sent++;
	endtask

	task automatic write_slot_length(input logic [TIME_W-1:0] len);
		cfg_valid <= 1'b1;
		slot_length_ns <= len;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		cur_len = (len == '0) ? 64'd1 : len;
		settings++;
	endtask

	task automatic wait_idle();
		do @(posedge clk); while (pending != 0);
	endtask

	// mostly aimed near the newest slot: inside the window, just behind it, small and
	// large advances, the odd huge jump; the rest is random-time noise
	task automatic make_random_req(
		input  bit                      big_jumps,
		output logic [OP_W-1:0]         op,
		output logic [TIME_W-1:0]       t,
		output logic signed [VAL_W-1:0] v
	);
		logic [TIME_W-1:0] slot;
		logic [TIME_W-1:0] step;
		logic [TIME_W-1:0] top_slot;
		logic [TIME_W-1:0] base;
		logic [TIME_W-1:0] rem;
		int                pick;
		pick = $urandom_range(0, 99);
		op = OP_W'($urandom_range(0, 3));
		case ($urandom_range(0, 9))
			0: v = INT_MAX;
			1: v = INT_MIN;
			2: v = VAL_W'($urandom_range(0, 20)) - 32'sd10;
			default: v = $urandom;
		endcase
		if (pick < 85) begin
			if (pick < 45) begin
				step = TIME_W'($urandom_range(0, NUM_ROWS - 1));
				slot = (step > cursor) ? 64'd0 : cursor - step;
			end else if (pick < 55) begin
				step = TIME_W'($urandom_range(NUM_ROWS, NUM_ROWS + 80));
				slot = (step > cursor) ? 64'd0 : cursor - step;
			end else begin
				if (pick < 75) begin
					step = TIME_W'($urandom_range(1, 8));
				end else begin
					step = TIME_W'($urandom_range(9, NUM_ROWS + 80));
					op = $urandom_range(0, 1) ? OP_SET : OP_ADD;
				end
				slot = (step > ALL_ONES - cursor) ? ALL_ONES : cursor + step;
				if (pick >= 82 && big_jumps)
					slot = {$urandom, $urandom};
			end
			top_slot = ALL_ONES / cur_len;
			if (slot > top_slot)
				slot = top_slot;
			base = slot * cur_len;
			rem = {$urandom, $urandom} % cur_len;
			if (rem > ALL_ONES - base)
				rem = ALL_ONES - base;
			t = base + rem;
		end else begin
			t = {$urandom, $urandom};
			if (!big_jumps)
				op = $urandom_range(0, 1) ? OP_GET : OP_SPARE;
		end
	endtask

	task automatic run_phase(input int count, input bit big_jumps);
		logic [OP_W-1:0]         op;
		logic [TIME_W-1:0]       t;
		logic signed [VAL_W-1:0] v;
		int                      done;
		int                      burst;
		int                      gap;
		done = 0;
		while (done < count) begin
			burst = $urandom_range(1, 12);
			repeat (burst) begin
				if (done < count) begin
					make_random_req(big_jumps, op, t, v);
					send_req(op, t, v);
					done++;
				end
			end
			if ($urandom_range(0, 2) == 0)
				gap = 0;
			else if ($urandom_range(0, 4) == 0)
				gap = $urandom_range(21, 120);
			else
				gap = $urandom_range(1, 20);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b0;
		wait_idle();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// longest slot: every timestamp lands in slot 0 or 1
		write_slot_length(ALL_ONES);
		send_req(OP_ADD, 64'd0, INT_MAX);
		send_req(OP_ADD, 64'd0, 32'sd1);
		send_req(OP_GET, ALL_ONES, 32'sd0);
		send_req(OP_SET, ALL_ONES, INT_MIN);
		send_req(OP_ADD, ALL_ONES, -32'sd1);
		in_valid <= 1'b0;
		wait_idle();

		// zero length acts as one
		write_slot_length('0);
		send_req(OP_GET, 64'd1023, 32'sd0);
		send_req(OP_SPARE, 64'd0, 32'sd0);
		send_req(OP_GET, 64'd1024, 32'sd0);
		send_req(OP_SPARE, ALL_ONES, 32'sd0);
		send_req(OP_ADD, 64'd1024, 32'sd5);
		send_req(OP_GET, 64'd0, 32'sd0);
		send_req(OP_SET, 64'd1, -32'sd7);
		send_req(OP_ADD, 64'd1, INT_MIN);
		send_req(OP_ADD, 64'd1030, -32'sd3);
		send_req(OP_SET, 64'd2054, 32'sd9);
		send_req(OP_GET, 64'd1031, 32'sd0);
		send_req(OP_GET, 64'd1030, 32'sd0);
		send_req(OP_SET, 64'd5, 32'sd1);
		send_req(OP_ADD, 64'd3077, 32'sd2);
		send_req(OP_GET, 64'd2054, 32'sd0);
		directed = sent;
		in_valid <= 1'b0;
		wait_idle();

		write_slot_length(64'd1000);
		run_phase(180, 1'b0);
		write_slot_length(64'd3);
		run_phase(180, 1'b0);
		write_slot_length(64'($urandom_range(2, 1 << 20)));
		run_phase(180, 1'b0);
		write_slot_length(64'd1);
		run_phase(190, 1'b1);

		repeat (1100) @(posedge clk);
		$display("Compared %0d results for %0d requests (%0d directed) over %0d slot lengths,",
			checked, sent, directed, settings);
		$display("including zero and all-ones lengths, window advances, full clears and stalls.");
		if (mismatches == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// result side: stall patterns of varying shape, plus two long hold-offs
	initial begin
		int mode;
		int span;
		int last_hold;
		last_hold = -1;
		wait (arst_n === 1'b1);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(16, 96);
			repeat (span) begin
				@(posedge clk);
				if (out_valid && out_ready)
					seen++;
				if ((seen == 200 || seen == 550) && seen != last_hold) begin
					last_hold = seen;
					out_ready <= 1'b0;
					repeat (400) @(posedge clk);
				end else begin
					case (mode)
						0: out_ready <= 1'b1;
						1: out_ready <= ~out_ready;
						2: out_ready <= ($urandom_range(0, 3) != 0);
						default: out_ready <= ($urandom_range(0, 3) == 0);
					endcase
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

endmodule
